// File: rtl/heading_pid_with_output_clamp_unit_defines.svh
// Assertion macros shared by the heading controller RTL.
`ifndef HEADING_PID_WITH_OUTPUT_CLAMP_UNIT_DEFINES_SVH
`define HEADING_PID_WITH_OUTPUT_CLAMP_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HPID_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("heading controller assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HPID_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("heading controller assertion failed");

`endif

// File: rtl/hpid_pkg.sv
package hpid_pkg;

  localparam int WINDOW_DEPTH_DEF = 10;

  localparam int ERR_W   = 24;   // width of a stored absolute error
  localparam int GAIN_W  = 20;
  localparam int SPEED_W = 16;
  localparam int POWER_W = 7;
  localparam int SCALE_W = 16;
  localparam int FRAC_W  = 16;   // Q16 fraction bits
  localparam int DRIVE_W = 8;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 8'd127;

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 20'd39322;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 20'd393;
  localparam logic [GAIN_W-1:0]  RATE_GAIN_RST    = 20'd7864;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST    = 16'd810;
  localparam logic [POWER_W-1:0] MAX_POWER_RST    = 7'd81;
  localparam logic [SPEED_W-1:0] MIN_SPEED_RST    = 16'd10;
  localparam logic [POWER_W-1:0] MIN_POWER_RST    = 7'd2;
  localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RST = 16'd6554;

  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_RATE_GAIN    = 3'd2,
    REG_MAX_SPEED    = 3'd3,
    REG_MAX_POWER    = 3'd4,
    REG_MIN_SPEED    = 3'd5,
    REG_MIN_POWER    = 3'd6,
    REG_OUTPUT_SCALE = 3'd7
  } reg_idx_e;

endpackage

// File: rtl/heading_pid_with_output_clamp_unit.sv
// Paths: a zero error goes from ST_IDLE straight to ST_FINISH and the output register;
//   any other runs ST_SUM, the 20-step MAC and ST_ROUND, then the 16-step scale unless
//   the speed clamps to max or min power. Input is taken only in ST_IDLE: a transaction
//   waits for the last; a result held in the output register stalls the input meanwhile.
// Reset (rst_ni low, asynchronous): registers take their defaults, ring reads as
//   all zeros through per-entry valid bits, slot and running sum clear to zero.
`include "heading_pid_with_output_clamp_unit_defines.svh"

module heading_pid_with_output_clamp_unit #(
  parameter int WINDOW_DEPTH = hpid_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // [23:0] target_heading, [47:24] encoder_position, [63:48] motor_rpm
  input  logic [63:0]                 s_axis_tdata_i,
  // output stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [7:0] drive_power
  output logic [hpid_pkg::DRIVE_W-1:0] m_axis_tdata_o,
  // configuration port
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [hpid_pkg::APB_AW-1:0]  paddr_i,
  input  logic [hpid_pkg::APB_DW-1:0]  pwdata_i,
  output logic [hpid_pkg::APB_DW-1:0]  prdata_o,
  output logic                        pready_o
);

  localparam int ERR_W  = hpid_pkg::ERR_W;
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W  = ERR_W + $clog2(WINDOW_DEPTH);
  // gains are 20 bits and three terms are summed
  localparam int ACC_W  = SUM_W + 23;
  localparam int SPD_W  = ACC_W - hpid_pkg::FRAC_W;
  localparam int CNT_W  = $clog2(hpid_pkg::GAIN_W);
  localparam int DIFF_W = ERR_W + 1;
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW_DEPTH * ((1 << ERR_W) - 1));
  localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(hpid_pkg::GAIN_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MAC,
    ST_ROUND,
    ST_SCALE,
    ST_FINISH
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [hpid_pkg::GAIN_W-1:0]  prop_gain_q, integ_gain_q, rate_gain_q;
  logic [hpid_pkg::SPEED_W-1:0] max_speed_q, min_speed_q;
  logic [hpid_pkg::POWER_W-1:0] max_power_q, min_power_q;
  logic [hpid_pkg::SCALE_W-1:0] output_scale_q;
  hpid_pkg::reg_idx_e           reg_idx;
  logic                         cfg_we;

  assign reg_idx  = hpid_pkg::reg_idx_e'(paddr_i[4:2]);
  assign cfg_we   = psel_i & penable_i & pwrite_i & pready_o;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= hpid_pkg::PROP_GAIN_RST;
      integ_gain_q   <= hpid_pkg::INTEG_GAIN_RST;
      rate_gain_q    <= hpid_pkg::RATE_GAIN_RST;
      max_speed_q    <= hpid_pkg::MAX_SPEED_RST;
      max_power_q    <= hpid_pkg::MAX_POWER_RST;
      min_speed_q    <= hpid_pkg::MIN_SPEED_RST;
      min_power_q    <= hpid_pkg::MIN_POWER_RST;
      output_scale_q <= hpid_pkg::OUTPUT_SCALE_RST;
    end else if (cfg_we) begin
      case (reg_idx)
        hpid_pkg::REG_PROP_GAIN:    prop_gain_q    <= pwdata_i[hpid_pkg::GAIN_W-1:0];
        hpid_pkg::REG_INTEG_GAIN:   integ_gain_q   <= pwdata_i[hpid_pkg::GAIN_W-1:0];
        hpid_pkg::REG_RATE_GAIN:    rate_gain_q    <= pwdata_i[hpid_pkg::GAIN_W-1:0];
        hpid_pkg::REG_MAX_SPEED:    max_speed_q    <= pwdata_i[hpid_pkg::SPEED_W-1:0];
        hpid_pkg::REG_MAX_POWER:    max_power_q    <= pwdata_i[hpid_pkg::POWER_W-1:0];
        hpid_pkg::REG_MIN_SPEED:    min_speed_q    <= pwdata_i[hpid_pkg::SPEED_W-1:0];
        hpid_pkg::REG_MIN_POWER:    min_power_q    <= pwdata_i[hpid_pkg::POWER_W-1:0];
        hpid_pkg::REG_OUTPUT_SCALE: output_scale_q <= pwdata_i[hpid_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    case (reg_idx)
      hpid_pkg::REG_PROP_GAIN:    prdata_o = {12'd0, prop_gain_q};
      hpid_pkg::REG_INTEG_GAIN:   prdata_o = {12'd0, integ_gain_q};
      hpid_pkg::REG_RATE_GAIN:    prdata_o = {12'd0, rate_gain_q};
      hpid_pkg::REG_MAX_SPEED:    prdata_o = {16'd0, max_speed_q};
      hpid_pkg::REG_MAX_POWER:    prdata_o = {25'd0, max_power_q};
      hpid_pkg::REG_MIN_SPEED:    prdata_o = {16'd0, min_speed_q};
      hpid_pkg::REG_MIN_POWER:    prdata_o = {25'd0, min_power_q};
      hpid_pkg::REG_OUTPUT_SCALE: prdata_o = {16'd0, output_scale_q};
      default:                    prdata_o = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input capture: error = target - position, and its magnitude
  // ---------------------------------------------------------------------------
  logic              in_acc;
  logic [DIFF_W-1:0] err_c, aerr_full;
  logic [ERR_W-1:0]  aerr_c;

  assign err_c = {s_axis_tdata_i[23], s_axis_tdata_i[23:0]}
               - {s_axis_tdata_i[47], s_axis_tdata_i[47:24]};
  assign aerr_full = err_c[DIFF_W-1] ? (DIFF_W'(0) - err_c) : err_c;
  // saturate the magnitude to the ring entry width
  assign aerr_c = aerr_full[DIFF_W-1] ? {ERR_W{1'b1}} : aerr_full[ERR_W-1:0];

  // ---------------------------------------------------------------------------
  // Error ring: memory with a registered read, valid bits stand in for clearing
  // ---------------------------------------------------------------------------
  logic [ERR_W-1:0]        ring_mem [WINDOW_DEPTH];
  logic [ERR_W-1:0]        ring_rd_q;
  logic [WINDOW_DEPTH-1:0] ring_vld_q;
  logic                    ring_we;

  state_e                  state_q;
  logic [SLOT_W-1:0]       slot_q, slot_nxt;
  logic [ERR_W-1:0]        aerr_q;
  logic [DIFF_W-1:0]       err_q;
  logic [15:0]             rpm_q;
  logic [SUM_W-1:0]        sum_q;
  logic [ERR_W-1:0]        old_err;

  assign ring_we  = (state_q == ST_SUM);
  assign slot_nxt = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
  assign old_err  = ring_vld_q[slot_q] ? ring_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot_q] <= aerr_q;
    end
    ring_rd_q <= ring_mem[slot_q];
  end

  // ---------------------------------------------------------------------------
  // Bit-serial datapath
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_q, mac_d, scl_d;
  logic signed [ACC_W-1:0] t_prop, t_integ, t_rate;
  logic [CNT_W-1:0]        cnt_q;
  logic                    neg_q;
  logic [hpid_pkg::SPEED_W-1:0] amag_q;
  logic [hpid_pkg::DRIVE_W-1:0] drv_q, m_data_q;
  logic                    m_valid_q;

  // one gain bit per cycle, most significant first
  assign t_prop  = prop_gain_q[cnt_q]
                 ? {{(ACC_W-DIFF_W){err_q[DIFF_W-1]}}, err_q} : '0;
  assign t_integ = integ_gain_q[cnt_q] ? {{(ACC_W-SUM_W){1'b0}}, sum_q} : '0;
  assign t_rate  = rate_gain_q[cnt_q] ? {{(ACC_W-16){rpm_q[15]}}, rpm_q} : '0;
  assign mac_d   = {acc_q[ACC_W-2:0], 1'b0} + t_prop + t_integ - t_rate;

  // one scale bit per cycle on the speed magnitude
  assign scl_d = {acc_q[ACC_W-2:0], 1'b0}
               + (output_scale_q[cnt_q[3:0]]
                  ? {{(ACC_W-hpid_pkg::SPEED_W){1'b0}}, amag_q} : '0);

  // speed = acc / 2^16 truncated toward zero
  logic             acc_neg, rnd;
  logic [SPD_W-1:0] spd_c, aspd_c;
  logic             over_max, under_min;
  logic [hpid_pkg::DRIVE_W-1:0] max_drv, min_drv;

  assign acc_neg  = acc_q[ACC_W-1];
  assign rnd      = acc_neg & (acc_q[hpid_pkg::FRAC_W-1:0] != '0);
  assign spd_c    = acc_q[ACC_W-1:hpid_pkg::FRAC_W] + SPD_W'(rnd);
  assign aspd_c   = acc_neg ? (SPD_W'(0) - spd_c) : spd_c;
  assign over_max = aspd_c > {{(SPD_W-hpid_pkg::SPEED_W){1'b0}}, max_speed_q};
  assign under_min = (spd_c != '0)
                   && (aspd_c < {{(SPD_W-hpid_pkg::SPEED_W){1'b0}}, min_speed_q});
  assign max_drv  = acc_neg ? (8'd0 - {1'b0, max_power_q}) : {1'b0, max_power_q};
  assign min_drv  = acc_neg ? (8'd0 - {1'b0, min_power_q}) : {1'b0, min_power_q};

  // final scaled magnitude, saturated and signed
  logic [15:0]                  smag;
  logic [hpid_pkg::DRIVE_W-1:0] ssat, sdrv;

  assign smag = scl_d[31:16];
  assign ssat = (smag > {8'd0, hpid_pkg::DRIVE_MAX}) ? hpid_pkg::DRIVE_MAX : smag[7:0];
  assign sdrv = neg_q ? (8'd0 - ssat) : ssat;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slot_q     <= '0;
      sum_q      <= '0;
      ring_vld_q <= '0;
      m_valid_q  <= 1'b0;
      cnt_q      <= '0;
    end else begin
      // drop the output once taken; in ST_FINISH the load below handles it
      if (m_valid_q && m_axis_tready_i && (state_q != ST_FINISH)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            err_q  <= err_c;
            aerr_q <= aerr_c;
            rpm_q  <= s_axis_tdata_i[63:48];
            drv_q  <= '0;
            // zero error leaves the ring alone
            state_q <= (err_c == '0) ? ST_FINISH : ST_SUM;
          end
        end
        ST_SUM: begin
          // replace the oldest entry and keep the window sum running
          sum_q              <= sum_q - SUM_W'(old_err) + SUM_W'(aerr_q);
          ring_vld_q[slot_q] <= 1'b1;
          slot_q             <= slot_nxt;
          acc_q              <= '0;
          cnt_q              <= MAC_LAST;
          state_q            <= ST_MAC;
        end
        ST_MAC: begin
          acc_q <= mac_d;
          if (cnt_q == '0) begin
            state_q <= ST_ROUND;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_ROUND: begin
          neg_q <= acc_neg;
          if (over_max) begin
            drv_q   <= max_drv;
            state_q <= ST_FINISH;
          end else if (under_min) begin
            drv_q   <= min_drv;
            state_q <= ST_FINISH;
          end else begin
            // magnitude is at most max_speed here, so it fits the speed width
            amag_q  <= aspd_c[hpid_pkg::SPEED_W-1:0];
            acc_q   <= '0;
            cnt_q   <= CNT_W'(hpid_pkg::SCALE_W - 1);
            state_q <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          acc_q <= scl_d;
          if (cnt_q == '0) begin
            drv_q   <= sdrv;
            state_q <= ST_FINISH;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= drv_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic zero_acc;

  assign zero_acc = in_acc && (err_c == '0);

  `HPID_ASSERT_NXT(a_zero_err_skips_ring, clk_i, rst_ni, zero_acc, state_q == ST_FINISH)
  `HPID_ASSERT_NXT(a_zero_err_keeps_sum, clk_i, rst_ni, zero_acc, $stable({slot_q, sum_q}))
  `HPID_ASSERT_IMP(a_sum_bounded, clk_i, rst_ni, 1'b1, sum_q <= SUM_MAX)
  `HPID_ASSERT_IMP(a_mac_count_range, clk_i, rst_ni, state_q == ST_MAC, cnt_q <= MAC_LAST)
  `HPID_ASSERT_IMP(a_drive_in_range, clk_i, rst_ni, m_valid_q, m_data_q != 8'h80)

endmodule

// File: bench/heading_pid_with_output_clamp_unit_tb.sv
`timescale 1ns / 100ps

module heading_pid_with_output_clamp_unit_tb;

  // One input transaction, packed as on s_axis_tdata_i (target in the low bits).
  typedef struct packed {
    logic signed [15:0] rpm;
    logic signed [23:0] position;
    logic signed [23:0] target;
  } heading_fix_t;

  // Register sets that the phases cycle through.
  typedef enum int {
    CFG_KEEP,
    CFG_DEFAULTS,
    CFG_ALL_ONES,
    CFG_ALL_ZEROS,
    CFG_CROSSED,
    CFG_RANDOM
  } cfg_mode_e;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned IDLE_PCT       = 12;
  localparam int unsigned TAIL_CYCLES    = 50;

  // Drive predictor and store of expected drive values.
  class heading_drive_scoreboard;
    localparam int DEPTH = hpid_pkg::WINDOW_DEPTH_DEF;
    localparam longint ABS_ERR_MAX = (longint'(1) << hpid_pkg::ERR_W) - 1;
    localparam longint Q_ONE = longint'(1) << hpid_pkg::FRAC_W;

    logic [31:0]                 setting [8];
    logic [hpid_pkg::ERR_W-1:0]  abs_err_ring [DEPTH];
    int unsigned                 ring_slot;
    logic [hpid_pkg::DRIVE_W-1:0] drive_expected_q [$];

    int unsigned mismatches, fixes_seen, drives_checked;
    int unsigned n_on_target, n_max_power, n_min_power, n_scaled, n_clipped;

    function new();
      for (int i = 0; i < 8; i++) setting[i] = reset_value(hpid_pkg::reg_idx_e'(i));
      foreach (abs_err_ring[i]) abs_err_ring[i] = '0;
      ring_slot = 0;
    endfunction

    static function logic [31:0] reset_value(hpid_pkg::reg_idx_e r);
      case (r)
        hpid_pkg::REG_PROP_GAIN:  return 32'(hpid_pkg::PROP_GAIN_RST);
        hpid_pkg::REG_INTEG_GAIN: return 32'(hpid_pkg::INTEG_GAIN_RST);
        hpid_pkg::REG_RATE_GAIN:  return 32'(hpid_pkg::RATE_GAIN_RST);
        hpid_pkg::REG_MAX_SPEED:  return 32'(hpid_pkg::MAX_SPEED_RST);
        hpid_pkg::REG_MAX_POWER:  return 32'(hpid_pkg::MAX_POWER_RST);
        hpid_pkg::REG_MIN_SPEED:  return 32'(hpid_pkg::MIN_SPEED_RST);
        hpid_pkg::REG_MIN_POWER:  return 32'(hpid_pkg::MIN_POWER_RST);
        default:                  return 32'(hpid_pkg::OUTPUT_SCALE_RST);
      endcase
    endfunction

    static function logic [31:0] field_mask(hpid_pkg::reg_idx_e r);
      case (r)
        hpid_pkg::REG_PROP_GAIN, hpid_pkg::REG_INTEG_GAIN, hpid_pkg::REG_RATE_GAIN:
          return (32'd1 << hpid_pkg::GAIN_W) - 1;
        hpid_pkg::REG_MAX_SPEED, hpid_pkg::REG_MIN_SPEED:
          return (32'd1 << hpid_pkg::SPEED_W) - 1;
        hpid_pkg::REG_MAX_POWER, hpid_pkg::REG_MIN_POWER:
          return (32'd1 << hpid_pkg::POWER_W) - 1;
        default:
          return (32'd1 << hpid_pkg::SCALE_W) - 1;
      endcase
    endfunction

    function void write_reg(hpid_pkg::reg_idx_e r, logic [31:0] v);
      setting[r] = v & field_mask(r);
    endfunction

    // Advance the error ring and work out the drive for one transaction.
    function logic [hpid_pkg::DRIVE_W-1:0] predict_drive(heading_fix_t f);
      longint err, aerr, sum, acc, speed, aspeed, drive;
      err = longint'(f.target) - longint'(f.position);
      if (err == 0) begin
        n_on_target++;
        return '0;
      end
      aerr = (err < 0) ? -err : err;
      if (aerr > ABS_ERR_MAX) aerr = ABS_ERR_MAX;
      abs_err_ring[ring_slot] = aerr[hpid_pkg::ERR_W-1:0];
      ring_slot = (ring_slot + 1 >= DEPTH) ? 0 : ring_slot + 1;
      sum = 0;
      foreach (abs_err_ring[i]) sum += longint'(abs_err_ring[i]);

      acc = longint'(setting[hpid_pkg::REG_PROP_GAIN]) * err
          + longint'(setting[hpid_pkg::REG_INTEG_GAIN]) * sum
          - longint'(setting[hpid_pkg::REG_RATE_GAIN]) * longint'(f.rpm);
      speed  = acc / Q_ONE;
      aspeed = (speed < 0) ? -speed : speed;

      if (aspeed > longint'(setting[hpid_pkg::REG_MAX_SPEED])) begin
        n_max_power++;
        drive = (speed < 0) ? -longint'(setting[hpid_pkg::REG_MAX_POWER])
                            : longint'(setting[hpid_pkg::REG_MAX_POWER]);
      end else if (speed != 0 && aspeed < longint'(setting[hpid_pkg::REG_MIN_SPEED])) begin
        n_min_power++;
        drive = (speed < 0) ? -longint'(setting[hpid_pkg::REG_MIN_POWER])
                            : longint'(setting[hpid_pkg::REG_MIN_POWER]);
      end else begin
        n_scaled++;
        drive = (speed * longint'(setting[hpid_pkg::REG_OUTPUT_SCALE])) / Q_ONE;
        if (drive > 127 || drive < -127) n_clipped++;
        if (drive > 127) drive = 127;
        if (drive < -127) drive = -127;
      end
      return drive[hpid_pkg::DRIVE_W-1:0];
    endfunction

    function void note_fix(heading_fix_t f);
      fixes_seen++;
      drive_expected_q.push_back(predict_drive(f));
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_drive(logic [hpid_pkg::DRIVE_W-1:0] got);
      logic [hpid_pkg::DRIVE_W-1:0] want;
      drives_checked++;
      if (drive_expected_q.size() == 0) begin
        report($sformatf("drive %0d with no transaction outstanding", $signed(got)));
      end else begin
        want = drive_expected_q.pop_front();
        if (got !== want)
          report($sformatf("drive_power got %0d (0x%h), want %0d",
                           $signed(got), got, $signed(want)));
      end
    endtask

    function int pending();
      return drive_expected_q.size();
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_tvalid;
  logic                         s_tready;
  heading_fix_t                 s_tdata;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [hpid_pkg::DRIVE_W-1:0] m_tdata;
  logic                         psel, penable, pwrite;
  logic [hpid_pkg::APB_AW-1:0]  paddr;
  logic [hpid_pkg::APB_DW-1:0]  pwdata, prdata;
  logic                         pready;

  heading_drive_scoreboard sb;
  bit          steady;             // suppress random idling on both sides
  int unsigned holdoffs_asked;     // raised by the sender, served by the receiver
  int unsigned holdoffs_done;
  int unsigned settings_used;
  int unsigned cycle_count = 0;

  heading_pid_with_output_clamp_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d drive values outstanding",
               cycle_count, sb.pending());
      $display("FAIL heading_pid_with_output_clamp_unit");
      $finish;
    end
  end

  // Monitor both streams on the rising edge; inputs only move on the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) sb.note_fix(s_tdata);
      if (m_tvalid && m_tready) sb.check_drive(m_tdata);
    end
  end

  // Receiver: random backpressure, plus long hold-offs on request so the
  // block fills up and has to stall its input.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holdoffs_asked != holdoffs_done) begin
        holdoffs_done++;
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(negedge clk_i);
      end
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // One APB transfer: setup cycle, then access until pready. psel stays high
  // across back-to-back transfers; the caller drops it.
  task automatic apb_xfer(input bit wr, input hpid_pkg::reg_idx_e r,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr) sb.write_reg(r, wdata);
    @(negedge clk_i);
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] setting_value(cfg_mode_e mode, hpid_pkg::reg_idx_e r);
    logic [31:0] v;
    case (mode)
      CFG_ALL_ONES:  return '1;
      CFG_ALL_ZEROS: return '0;
      CFG_CROSSED: begin
        // min_speed above max_speed: the max test has to win.
        case (r)
          hpid_pkg::REG_MAX_SPEED: return 32'd300;
          hpid_pkg::REG_MIN_SPEED: return 32'd2000;
          hpid_pkg::REG_MIN_POWER: return 32'd127;
          default:                 return heading_drive_scoreboard::reset_value(r);
        endcase
      end
      CFG_RANDOM: begin
        case (r)
          hpid_pkg::REG_PROP_GAIN, hpid_pkg::REG_INTEG_GAIN, hpid_pkg::REG_RATE_GAIN:
            v = $urandom_range(0, 131071);
          hpid_pkg::REG_MAX_SPEED: v = $urandom_range(0, 3000);
          hpid_pkg::REG_MIN_SPEED: v = $urandom_range(0, 200);
          hpid_pkg::REG_MAX_POWER, hpid_pkg::REG_MIN_POWER: v = $urandom_range(0, 127);
          default: v = $urandom_range(0, 65535);
        endcase
        // Junk above the field width must be dropped by the block.
        return v | ($urandom & ~heading_drive_scoreboard::field_mask(r));
      end
      default: return heading_drive_scoreboard::reset_value(r);
    endcase
  endfunction

  // Write each register unless the mode is CFG_KEEP, then read it back against the masked value.
  task automatic program_registers(cfg_mode_e mode);
    hpid_pkg::reg_idx_e r;
    logic [31:0]        rd;
    settings_used++;
    for (int i = 0; i < 8; i++) begin
      r = hpid_pkg::reg_idx_e'(i);
      if (mode != CFG_KEEP) apb_xfer(1'b1, r, setting_value(mode, r), rd);
      apb_xfer(1'b0, r, '0, rd);
      if (rd !== sb.setting[r])
        sb.report($sformatf("%s reads 0x%h, want 0x%h", r.name(), rd, sb.setting[r]));
    end
    psel <= 1'b0;
  endtask

  // Offer one transaction, sometimes after a gap, and hold it until taken.
  task automatic send_fix(heading_fix_t f);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      repeat (($urandom_range(7) == 0) ? $urandom_range(8, 50) : $urandom_range(1, 5))
        @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= f;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic send_fields(int tgt, int pos, int rpm);
    heading_fix_t f;
    f.target   = 24'(tgt);
    f.position = 24'(pos);
    f.rpm      = 16'(rpm);
    send_fix(f);
  endtask

  // Mostly small errors around the control band, with zero errors, medium
  // errors and full-range noise mixed in.
  function automatic heading_fix_t random_fix();
    heading_fix_t f;
    int unsigned  pick;
    int           pos, mag;
    pick = $urandom_range(99);
    f.rpm = ($urandom_range(9) == 0) ? 16'($urandom)
                                     : 16'(int'($urandom_range(0, 1000)) - 500);
    pos = int'($urandom_range(0, 16000000)) - 8000000;
    if (pick < 10) begin
      f.position = 24'($urandom);
      f.target   = f.position;
    end else if (pick < 90) begin
      if (pick < 75)
        mag = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 1500);
      else
        mag = $urandom_range(1, 200000);
      if ($urandom_range(1)) mag = -mag;
      f.position = 24'(pos);
      f.target   = 24'(pos + mag);
    end else begin
      f.target   = 24'($urandom);
      f.position = 24'($urandom);
    end
    return f;
  endfunction

  // Drop valid and wait for every outstanding drive value to come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(cfg_mode_e mode, int unsigned count, bit calm, bit holdoff);
    drain();
    if (mode != CFG_KEEP) program_registers(mode);
    steady = calm;
    for (int unsigned i = 0; i < count; i++) begin
      if (holdoff && i == 20) holdoffs_asked++;
      send_fix(random_fix());
    end
  endtask

  // Directed set under the reset defaults.
  task automatic directed_fixes();
    send_fields(8388607, -8388608, 0);       // largest positive error
    send_fields(-8388608, 8388607, 0);       // largest negative error
    send_fields(8388607, 8388607, 32767);    // on target at the top
    send_fields(-8388608, -8388608, -32768); // on target at the bottom
    send_fields(1, 0, 0);
    send_fields(-1, 0, 0);
    send_fields(5, 0, 32767);                // integral of the big errors still dominates the rate term
    send_fields(-5, 0, -32768);
    // Flush the big errors out of the window with steady small ones.
    for (int i = 0; i < 10; i++) send_fields(1100 + i, 1000, 0);
    send_fields(-100, 0, 0);                 // proportional term outweighs the integral, scaled
    send_fields(1, 0, 0);                    // small speed, min power
    send_fields(-1, 0, 40);
    send_fields(3, 0, -6000);                // rate term pushes speed up, still under max_speed, scaled
    send_fields(0, 0, 1234);
  endtask

  initial begin
    sb             = new();
    rst_ni         = 1'b0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    steady         = 1'b0;
    holdoffs_asked = 0;
    holdoffs_done  = 0;
    settings_used  = 0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset defaults: read back only, then directed and random traffic.
    program_registers(CFG_KEEP);
    directed_fixes();
    run_phase(CFG_KEEP,      150, 1'b0, 1'b0);
    run_phase(CFG_ALL_ONES,  120, 1'b0, 1'b0);
    run_phase(CFG_ALL_ZEROS, 100, 1'b0, 1'b0);
    run_phase(CFG_CROSSED,   150, 1'b0, 1'b0);
    run_phase(CFG_RANDOM,    200, 1'b1, 1'b0);  // no idling on either side
    run_phase(CFG_RANDOM,    200, 1'b0, 1'b1);  // long receiver hold-off
    run_phase(CFG_RANDOM,    200, 1'b0, 1'b0);
    run_phase(CFG_DEFAULTS,  180, 1'b0, 1'b0);
    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    // Anything still queued never came out.
    if (sb.pending() != 0)
      sb.report($sformatf("%0d drive values never arrived", sb.pending()));

    $display("Ran %0d heading transactions over %0d register settings, %0d drives checked.",
             sb.fixes_seen, settings_used, sb.drives_checked);
    $display("Paths: %0d on target, %0d max power, %0d min power, %0d scaled (%0d clipped).",
             sb.n_on_target, sb.n_max_power, sb.n_min_power, sb.n_scaled, sb.n_clipped);
    if (sb.mismatches == 0) begin
      $display("PASS heading_pid_with_output_clamp_unit");
    end else begin
      $display("FAIL heading_pid_with_output_clamp_unit");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/hpid_pkg.sv
rtl/heading_pid_with_output_clamp_unit.sv
bench/heading_pid_with_output_clamp_unit_tb.sv
